/* rtl/assert_macros.svh */
// Assertion macros used by the sequencer RTL back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/i2cms_pkg.sv */
// Types and constants of the I2C master byte sequencer.
package i2cms_pkg;

  // command codes
  typedef enum logic [1:0] {
    OP_START_ADDR = 2'd0,
    OP_WRITE      = 2'd1,
    OP_READ       = 2'd2,
    OP_STOP       = 2'd3
  } op_t;

  // configuration register indexes
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SLAVE_ADDRESS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD   = 1'd1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [6:0] SLAVE_ADDRESS_RST = 7'd0;
  localparam logic [9:0] HALF_PERIOD_RST   = 10'd10;

  // pin triples: {scl, sda, drive}
  localparam logic [2:0] PINS_IDLE      = 3'b111;
  localparam logic [2:0] PINS_AFTER_ACK = 3'b001;
  localparam logic [2:0] PINS_AFTER_RD  = 3'b011;

  // data setup hold before a rising clock edge
  localparam logic [9:0] SETUP_US = 10'd1;

  // queue between front and back, depth a power of two
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

  // work the back end carries out for one command
  typedef enum logic [2:0] {
    JOB_IGNORE,
    JOB_ADDR,
    JOB_WRITE,
    JOB_READ,
    JOB_STOP
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       restart;     // stop and wait before the start
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       final_read;
    logic [7:0] slave_bits;
    logic [2:0] pins;        // pins at the time of an ignored command
  } job_t;

  // back end sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RSTOP,
    PH_WAIT,
    PH_START,
    PH_BITS,
    PH_ACK,
    PH_NSTOP,
    PH_RBITS,
    PH_RACK,
    PH_STOP,
    PH_IGN
  } phase_t;

  // one pin event word
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic [9:0] hold;
    logic [7:0] rdata;
    logic       ack;
    logic       err;
    logic       last;
  } event_t;

endpackage

/* rtl/i2cms_in_if.sv */
// Command channel: valid/ready handshake carrying one I2C master command.
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       read_not_write;
  logic [7:0] data_byte;
  logic       final_read;
  logic [7:0] slave_bits;
  logic       slave_ack_level;

  modport source (
    output valid, operation, read_not_write, data_byte, final_read, slave_bits,
           slave_ack_level,
    input  ready
  );
  modport sink (
    input  valid, operation, read_not_write, data_byte, final_read, slave_bits,
           slave_ack_level,
    output ready
  );
endinterface

/* rtl/i2cms_out_if.sv */
// Event channel: valid/ready handshake carrying one timed pin event.
interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic [9:0] hold_us;
  logic [7:0] read_data;
  logic       ack_seen;
  logic       error;
  logic       last_event;

  modport source (
    output valid, scl_level, sda_level, sda_drive, hold_us, read_data, ack_seen,
           error, last_event,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_drive, hold_us, read_data, ack_seen,
           error, last_event,
    output ready
  );
endinterface

/* rtl/i2cms_front.sv */
// Front end: takes commands, tracks bus state and queues a job per command.
module i2cms_front (
  input  logic             clk,
  input  logic             rst,
  i2cms_in_if.sink         cmd,
  input  logic [6:0]       slave_address,
  input  logic             q_ready,
  output logic             q_push,
  output i2cms_pkg::job_t  q_job
);

  logic       transfer_open, transfer_open_next;
  logic       aborted, aborted_next;
  logic [2:0] pin_levels, pin_levels_next;
  i2cms_pkg::op_t op;

  assign op        = i2cms_pkg::op_t'(cmd.operation);
  assign cmd.ready = q_ready;
  assign q_push    = cmd.valid && q_ready;

  // classify the command and predict the bus state it leaves
  always_comb begin
    q_job.kind         = i2cms_pkg::JOB_IGNORE;
    q_job.restart      = transfer_open;
    q_job.tx_byte      = cmd.data_byte;
    q_job.ack_level    = cmd.slave_ack_level;
    q_job.final_read   = cmd.final_read;
    q_job.slave_bits   = cmd.slave_bits;
    q_job.pins         = pin_levels;
    transfer_open_next = transfer_open;
    aborted_next       = aborted;
    pin_levels_next    = pin_levels;
    if (op == i2cms_pkg::OP_START_ADDR) begin
      q_job.kind         = i2cms_pkg::JOB_ADDR;
      q_job.tx_byte      = {slave_address, cmd.read_not_write};
      aborted_next       = cmd.slave_ack_level;
      transfer_open_next = !cmd.slave_ack_level;
      pin_levels_next    = cmd.slave_ack_level ? i2cms_pkg::PINS_IDLE
                                               : i2cms_pkg::PINS_AFTER_ACK;
    end else if (aborted || !transfer_open) begin
      q_job.kind = i2cms_pkg::JOB_IGNORE;
    end else begin
      case (op)
        i2cms_pkg::OP_WRITE: begin
          q_job.kind = i2cms_pkg::JOB_WRITE;
          if (cmd.slave_ack_level) begin
            transfer_open_next = 1'b0;
            aborted_next       = 1'b1;
            pin_levels_next    = i2cms_pkg::PINS_IDLE;
          end else begin
            pin_levels_next = i2cms_pkg::PINS_AFTER_ACK;
          end
        end
        i2cms_pkg::OP_READ: begin
          q_job.kind      = i2cms_pkg::JOB_READ;
          pin_levels_next = i2cms_pkg::PINS_AFTER_RD;
        end
        i2cms_pkg::OP_STOP: begin
          q_job.kind         = i2cms_pkg::JOB_STOP;
          transfer_open_next = 1'b0;
          pin_levels_next    = i2cms_pkg::PINS_IDLE;
        end
        default: begin
          q_job.kind = i2cms_pkg::JOB_IGNORE;
        end
      endcase
    end
  end

  // bus state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_open <= 1'b0;
      aborted       <= 1'b0;
      pin_levels    <= i2cms_pkg::PINS_IDLE;
    end else if (q_push) begin
      transfer_open <= transfer_open_next;
      aborted       <= aborted_next;
      pin_levels    <= pin_levels_next;
    end
  end

endmodule

/* rtl/i2cms_queue.sv */
// Short job queue between the front and back ends.
module i2cms_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cms_pkg::job_t  push_job,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output i2cms_pkg::job_t  head
);

  i2cms_pkg::job_t                   store [i2cms_pkg::Q_DEPTH];
  logic [i2cms_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [i2cms_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [i2cms_pkg::Q_CNT_W-1:0]     count;
  logic                              do_push, do_pop;

  assign ready   = (count != i2cms_pkg::Q_CNT_W'(i2cms_pkg::Q_DEPTH));
  assign valid   = (count != '0);
  assign head    = store[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/i2cms_back.sv */
// Back end: walks each job through its pin events into the output register.
`include "assert_macros.svh"
module i2cms_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [9:0]       half_period_us,
  input  logic             q_valid,
  input  i2cms_pkg::job_t  q_job,
  output logic             q_pop,
  i2cms_out_if.source      evt
);

  i2cms_pkg::phase_t phase, phase_next;
  logic [2:0]        sub, sub_next;
  logic [2:0]        bitn, bitn_next;
  i2cms_pkg::job_t   job;
  i2cms_pkg::event_t ev, ev_out;
  logic              ovalid;
  logic              advance;
  logic              tx_bit;

  assign q_pop   = (phase == i2cms_pkg::PH_IDLE) && q_valid;
  assign advance = (phase != i2cms_pkg::PH_IDLE) && (!ovalid || evt.ready);
  assign tx_bit  = job.tx_byte[bitn];

  // event for the present step and the step after it
  always_comb begin
    phase_next = phase;
    sub_next   = sub + 3'd1;
    bitn_next  = bitn;
    ev.scl     = 1'b0;
    ev.sda     = 1'b1;
    ev.drv     = 1'b1;
    ev.hold    = half_period_us;
    ev.rdata   = 8'd0;
    ev.ack     = 1'b0;
    ev.err     = 1'b0;
    ev.last    = 1'b0;
    case (phase)
      // stop condition: SCL rises with SDA low, then SDA rises
      i2cms_pkg::PH_RSTOP, i2cms_pkg::PH_NSTOP, i2cms_pkg::PH_STOP: begin
        ev.scl = (sub != 3'd0);
        ev.sda = (sub == 3'd2);
        if (sub == 3'd2) begin
          sub_next = 3'd0;
          if (phase == i2cms_pkg::PH_RSTOP) begin
            phase_next = i2cms_pkg::PH_WAIT;
          end else begin
            phase_next = i2cms_pkg::PH_IDLE;
            ev.last    = 1'b1;
            ev.err     = (phase == i2cms_pkg::PH_NSTOP);
          end
        end
      end
      i2cms_pkg::PH_WAIT: begin
        ev.scl     = 1'b1;
        phase_next = i2cms_pkg::PH_START;
        sub_next   = 3'd0;
      end
      // start condition: SDA falls under high SCL, then SCL falls
      i2cms_pkg::PH_START: begin
        ev.scl = (sub == 3'd0);
        ev.sda = 1'b0;
        if (sub == 3'd1) begin
          phase_next = i2cms_pkg::PH_BITS;
          sub_next   = 3'd0;
          bitn_next  = 3'd7;
        end
      end
      // one data bit: setup, clock high, clock low
      i2cms_pkg::PH_BITS: begin
        ev.sda = tx_bit;
        ev.scl = (sub == 3'd1);
        if (sub == 3'd0) begin
          ev.hold = i2cms_pkg::SETUP_US;
        end
        if (sub == 3'd2) begin
          sub_next = 3'd0;
          if (bitn == 3'd0) begin
            phase_next = i2cms_pkg::PH_ACK;
          end else begin
            bitn_next = bitn - 3'd1;
          end
        end
      end
      // acknowledge slot with SDA released, then driven low again
      i2cms_pkg::PH_ACK: begin
        ev.scl = (sub == 3'd1);
        ev.drv = (sub == 3'd2);
        ev.sda = (sub != 3'd2);
        if (sub == 3'd2) begin
          sub_next = 3'd0;
          if (!job.ack_level) begin
            phase_next = i2cms_pkg::PH_IDLE;
            ev.last    = 1'b1;
            ev.ack     = 1'b1;
          end else begin
            phase_next = i2cms_pkg::PH_NSTOP;
          end
        end
      end
      // one read slot with SDA released
      i2cms_pkg::PH_RBITS: begin
        ev.scl = (sub == 3'd0);
        ev.drv = 1'b0;
        if (sub == 3'd1) begin
          sub_next = 3'd0;
          if (bitn == 3'd0) begin
            phase_next = i2cms_pkg::PH_RACK;
          end else begin
            bitn_next = bitn - 3'd1;
          end
        end
      end
      // master ack or nack after a read
      i2cms_pkg::PH_RACK: begin
        ev.scl = (sub == 3'd2);
        ev.sda = (sub == 3'd0) || (sub == 3'd4) || job.final_read;
        if (sub == 3'd1) begin
          ev.hold = i2cms_pkg::SETUP_US;
        end
        if ((sub == 3'd4) || ((sub == 3'd3) && job.final_read)) begin
          phase_next = i2cms_pkg::PH_IDLE;
          sub_next   = 3'd0;
          ev.last    = 1'b1;
          ev.rdata   = job.slave_bits;
        end
      end
      // command dropped: repeat the present pins
      i2cms_pkg::PH_IGN: begin
        ev.scl     = job.pins[2];
        ev.sda     = job.pins[1];
        ev.drv     = job.pins[0];
        ev.hold    = 10'd0;
        ev.last    = 1'b1;
        ev.err     = 1'b1;
        phase_next = i2cms_pkg::PH_IDLE;
        sub_next   = 3'd0;
      end
      default: begin
        phase_next = i2cms_pkg::PH_IDLE;
        sub_next   = 3'd0;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cms_pkg::PH_IDLE;
      sub   <= 3'd0;
      bitn  <= 3'd7;
    end else if (q_pop) begin
      sub  <= 3'd0;
      bitn <= 3'd7;
      case (q_job.kind)
        i2cms_pkg::JOB_ADDR:
          phase <= q_job.restart ? i2cms_pkg::PH_RSTOP : i2cms_pkg::PH_START;
        i2cms_pkg::JOB_WRITE: phase <= i2cms_pkg::PH_BITS;
        i2cms_pkg::JOB_READ:  phase <= i2cms_pkg::PH_RBITS;
        i2cms_pkg::JOB_STOP:  phase <= i2cms_pkg::PH_STOP;
        default:              phase <= i2cms_pkg::PH_IGN;
      endcase
    end else if (advance) begin
      phase <= phase_next;
      sub   <= sub_next;
      bitn  <= bitn_next;
    end
  end

  // job held for the duration of its events
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (advance) begin
      ovalid <= 1'b1;
    end else if (evt.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_out <= ev;
    end
  end

  assign evt.valid      = ovalid;
  assign evt.scl_level  = ev_out.scl;
  assign evt.sda_level  = ev_out.sda;
  assign evt.sda_drive  = ev_out.drv;
  assign evt.hold_us    = ev_out.hold;
  assign evt.read_data  = ev_out.rdata;
  assign evt.ack_seen   = ev_out.ack;
  assign evt.error      = ev_out.err;
  assign evt.last_event = ev_out.last;

  `ASSERT_NEXT(a_last_ends_job, clk, rst, advance && ev.last, phase == i2cms_pkg::PH_IDLE, "sequencer kept running after the last event")
  `ASSERT_IMPLIES(a_released_high, clk, rst, ovalid && !ev_out.drv, ev_out.sda, "released SDA shown low")
  `ASSERT_IMPLIES(a_ign_kind, clk, rst, phase == i2cms_pkg::PH_IGN, job.kind == i2cms_pkg::JOB_IGNORE, "ignore phase for a live job")
  `ASSERT_IMPLIES(a_no_pop_busy, clk, rst, phase != i2cms_pkg::PH_IDLE, !q_pop, "job taken while sequencer busy")

endmodule

/* rtl/i2c_master_byte_sequencer_unit.sv */
// Top level of the I2C master byte sequencer: registers, front, queue and back.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+-----------------------------------------
//  cmd     | in  | valid/ready   | one master command with slave SDA levels
//  evt     | out | valid/ready   | one timed pin event
//  wr_*    | in  | write enable  | configuration register write
//
// Each command yields 1 to 36 events; the back end sends one event a cycle
// while evt is ready, and takes the next job off the queue only when idle.
// The front passes each command straight into a two-entry job queue, so
// commands keep flowing while the back end is busy or evt stalls, until it is full.
// Reset clears the queue and the sequencer and leaves the pins at SCL high,
// SDA high and driven, with no transfer open.
module i2c_master_byte_sequencer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [i2cms_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]    wr_data,
  i2cms_in_if.sink                            cmd,
  i2cms_out_if.source                         evt
);

  logic [6:0]      slave_address;
  logic [9:0]      half_period_us;
  logic            q_push, q_ready, q_pop, q_valid;
  i2cms_pkg::job_t push_job, head_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= i2cms_pkg::SLAVE_ADDRESS_RST;
      half_period_us <= i2cms_pkg::HALF_PERIOD_RST;
    end else if (wr_en) begin
      case (wr_index)
        i2cms_pkg::REG_SLAVE_ADDRESS: slave_address  <= wr_data[6:0];
        i2cms_pkg::REG_HALF_PERIOD:   half_period_us <= wr_data[9:0];
        default: begin
          slave_address <= slave_address;
        end
      endcase
    end
  end

  i2cms_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .slave_address (slave_address),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  i2cms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_job)
  );

  i2cms_back u_back (
    .clk            (clk),
    .rst            (rst),
    .half_period_us (half_period_us),
    .q_valid        (q_valid),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .evt            (evt)
  );

endmodule

/* test/tb.sv */
// Self-checking testbench for the I2C master byte sequencer: commands in, predicted pin events out.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    i2cms_pkg::op_t operation;
    logic           read_not_write;
    logic [7:0]     data_byte;
    logic           final_read;
    logic [7:0]     slave_bits;
    logic           slave_ack_level;
  } bus_cmd_t;

  logic                             clk;
  logic                             rst;
  logic                             wr_en;
  logic [i2cms_pkg::REG_IDX_W-1:0]  wr_index;
  logic [i2cms_pkg::CFG_DATA_W-1:0] wr_data;

  i2cms_in_if  cmd_if();
  i2cms_out_if evt_if();

  i2c_master_byte_sequencer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd_if),
    .evt      (evt_if)
  );

  // predictor copy of the registers and bus state
  logic [6:0] tgt_addr = i2cms_pkg::SLAVE_ADDRESS_RST;
  logic [9:0] half_us  = i2cms_pkg::HALF_PERIOD_RST;
  bit         xfer_open;
  bit         xfer_aborted;
  logic [2:0] pin_now = i2cms_pkg::PINS_IDLE;

  bus_cmd_t          cmd_backlog[$];
  i2cms_pkg::event_t due_events[$];
  int                cmds_issued;
  int                cmds_taken;
  int                mismatches;
  bit                cmd_taken_last;
  bit                full_rate;
  int                hold_off_left;
  bit                hold_off_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // one pin event; a released SDA always reads high
  function automatic void push_pin_event(bit scl, bit sda, bit drv, logic [9:0] hold);
    i2cms_pkg::event_t e;
    e = '0;
    e.scl  = scl;
    e.drv  = drv;
    e.sda  = drv ? sda : 1'b1;
    e.hold = hold;
    due_events.push_back(e);
    pin_now = {scl, e.sda, drv};
  endfunction

  function automatic void push_stop_edges();
    push_pin_event(1'b0, 1'b0, 1'b1, half_us);
    push_pin_event(1'b1, 1'b0, 1'b1, half_us);
    push_pin_event(1'b1, 1'b1, 1'b1, half_us);
  endfunction

  // eight data bits, then the ack slot; a nack closes the bus and aborts
  function automatic bit send_byte_poll(logic [7:0] b, bit ack_level);
    for (int i = 7; i >= 0; i--) begin
      push_pin_event(1'b0, b[i], 1'b1, i2cms_pkg::SETUP_US);
      push_pin_event(1'b1, b[i], 1'b1, half_us);
      push_pin_event(1'b0, b[i], 1'b1, half_us);
    end
    push_pin_event(1'b0, 1'b1, 1'b0, half_us);
    push_pin_event(1'b1, 1'b1, 1'b0, half_us);
    push_pin_event(1'b0, 1'b0, 1'b1, half_us);
    if (ack_level) begin
      push_stop_edges();
      xfer_open    = 1'b0;
      xfer_aborted = 1'b1;
    end
    return !ack_level;
  endfunction

  function automatic void predict_pin_events(bus_cmd_t c);
    bit                ackf;
    bit                err;
    logic [7:0]        rd;
    i2cms_pkg::event_t tail;
    ackf = 1'b0;
    err  = 1'b0;
    rd   = 8'h00;
    if (c.operation == i2cms_pkg::OP_START_ADDR) begin
      // repeated start: stop, wait one half period, then start
      if (xfer_open) begin
        push_stop_edges();
        push_pin_event(1'b1, 1'b1, 1'b1, half_us);
      end
      xfer_aborted = 1'b0;
      xfer_open    = 1'b0;
      push_pin_event(1'b1, 1'b0, 1'b1, half_us);
      push_pin_event(1'b0, 1'b0, 1'b1, half_us);
      if (send_byte_poll({tgt_addr, c.read_not_write}, c.slave_ack_level)) begin
        xfer_open = 1'b1;
        ackf      = 1'b1;
      end else begin
        err = 1'b1;
      end
    end else if (xfer_aborted || !xfer_open) begin
      // nothing to act on: echo the pins with no hold
      push_pin_event(pin_now[2], pin_now[1], pin_now[0], 10'd0);
      err = 1'b1;
    end else begin
      case (c.operation)
        i2cms_pkg::OP_WRITE: begin
          if (send_byte_poll(c.data_byte, c.slave_ack_level)) ackf = 1'b1;
          else err = 1'b1;
        end
        i2cms_pkg::OP_READ: begin
          for (int i = 0; i < 8; i++) begin
            push_pin_event(1'b1, 1'b1, 1'b0, half_us);
            push_pin_event(1'b0, 1'b1, 1'b0, half_us);
          end
          push_pin_event(1'b0, 1'b1, 1'b1, half_us);
          if (c.final_read) begin
            push_pin_event(1'b0, 1'b1, 1'b1, i2cms_pkg::SETUP_US);
            push_pin_event(1'b1, 1'b1, 1'b1, half_us);
            push_pin_event(1'b0, 1'b1, 1'b1, half_us);
          end else begin
            push_pin_event(1'b0, 1'b0, 1'b1, i2cms_pkg::SETUP_US);
            push_pin_event(1'b1, 1'b0, 1'b1, half_us);
            push_pin_event(1'b0, 1'b0, 1'b1, half_us);
            push_pin_event(1'b0, 1'b1, 1'b1, half_us);
          end
          rd = c.slave_bits;
        end
        default: begin
          push_stop_edges();
          xfer_open = 1'b0;
        end
      endcase
    end
    tail       = due_events.pop_back();
    tail.rdata = rd;
    tail.ack   = ackf;
    tail.err   = err;
    tail.last  = 1'b1;
    due_events.push_back(tail);
  endfunction

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic bus_cmd_t rand_cmd(i2cms_pkg::op_t op, int nack_pct);
    bus_cmd_t c;
    c.operation       = op;
    c.read_not_write  = 1'($urandom_range(1));
    c.data_byte       = 8'($urandom_range(255));
    c.final_read      = 1'($urandom_range(1));
    c.slave_bits      = 8'($urandom_range(255));
    c.slave_ack_level = ($urandom_range(99) < nack_pct);
    return c;
  endfunction

  function automatic void add_cmd(bus_cmd_t c);
    cmd_backlog.push_back(c);
    cmds_issued++;
  endfunction

  // mostly whole transfers with random content, some stray commands between
  task automatic queue_traffic(int n);
    int made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 15) begin
        add_cmd(rand_cmd(i2cms_pkg::op_t'($urandom_range(3)), 50));
      end else begin
        add_cmd(rand_cmd(i2cms_pkg::OP_START_ADDR, 10));
        made++;
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(1)) add_cmd(rand_cmd(i2cms_pkg::OP_WRITE, 8));
          else add_cmd(rand_cmd(i2cms_pkg::OP_READ, 50));
          made++;
        end
        if ($urandom_range(99) < 80) begin
          add_cmd(rand_cmd(i2cms_pkg::OP_STOP, 50));
          made++;
        end
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (cmds_taken != cmds_issued || due_events.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_bus(logic [6:0] addr, logic [9:0] half);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= i2cms_pkg::REG_SLAVE_ADDRESS;
    wr_data  <= {3'b000, addr};
    @(negedge clk);
    wr_index <= i2cms_pkg::REG_HALF_PERIOD;
    wr_data  <= half;
    @(negedge clk);
    wr_en    <= 1'b0;
    tgt_addr = addr;
    half_us  = half;
    @(posedge clk);
  endtask

  // command driver: next word once the last one was taken
  always @(negedge clk) begin
    bus_cmd_t c;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_taken_last) begin
      if (cmd_backlog.size() != 0 && (full_rate || $urandom_range(99) >= 32)) begin
        c = cmd_backlog.pop_front();
        cmd_if.valid           <= 1'b1;
        cmd_if.operation       <= c.operation;
        cmd_if.read_not_write  <= c.read_not_write;
        cmd_if.data_byte       <= c.data_byte;
        cmd_if.final_read      <= c.final_read;
        cmd_if.slave_bits      <= c.slave_bits;
        cmd_if.slave_ack_level <= c.slave_ack_level;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // event receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      evt_if.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      evt_if.ready  <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (!hold_off_done && cmds_taken >= 60) begin
      evt_if.ready  <= 1'b0;
      hold_off_left <= 400;
      hold_off_done <= 1'b1;
    end else begin
      evt_if.ready <= full_rate || ($urandom_range(99) >= 32);
    end
  end

  // monitor: predict on each command word, check each event word
  always @(posedge clk) begin
    bus_cmd_t          c;
    i2cms_pkg::event_t want;
    cmd_taken_last <= !rst && cmd_if.valid && cmd_if.ready;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      c.operation       = i2cms_pkg::op_t'(cmd_if.operation);
      c.read_not_write  = cmd_if.read_not_write;
      c.data_byte       = cmd_if.data_byte;
      c.final_read      = cmd_if.final_read;
      c.slave_bits      = cmd_if.slave_bits;
      c.slave_ack_level = cmd_if.slave_ack_level;
      predict_pin_events(c);
      cmds_taken++;
    end
    if (!rst && evt_if.valid && evt_if.ready) begin
      if (due_events.size() == 0) begin
        $error("pin event with none expected");
        mismatches++;
      end else begin
        want = due_events.pop_front();
        check_field("scl_level",  10'(want.scl),   10'(evt_if.scl_level));
        check_field("sda_level",  10'(want.sda),   10'(evt_if.sda_level));
        check_field("sda_drive",  10'(want.drv),   10'(evt_if.sda_drive));
        check_field("hold_us",    want.hold,       evt_if.hold_us);
        check_field("read_data",  10'(want.rdata), 10'(evt_if.read_data));
        check_field("ack_seen",   10'(want.ack),   10'(evt_if.ack_seen));
        check_field("error",      10'(want.err),   10'(evt_if.error));
        check_field("last_event", 10'(want.last),  10'(evt_if.last_event));
      end
    end
  end

  initial begin
    bus_cmd_t opening [23];
    opening = '{
      // nothing open yet: all ignored
      '{i2cms_pkg::OP_WRITE,      1'b0, 8'h12, 1'b0, 8'h00, 1'b0},
      '{i2cms_pkg::OP_READ,       1'b1, 8'h00, 1'b1, 8'hFF, 1'b0},
      '{i2cms_pkg::OP_STOP,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      // write transfer, byte extremes
      '{i2cms_pkg::OP_START_ADDR, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{i2cms_pkg::OP_WRITE,      1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{i2cms_pkg::OP_WRITE,      1'b1, 8'hFF, 1'b1, 8'hFF, 1'b0},
      // repeated start into a read
      '{i2cms_pkg::OP_START_ADDR, 1'b1, 8'hFF, 1'b1, 8'hFF, 1'b0},
      '{i2cms_pkg::OP_READ,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{i2cms_pkg::OP_READ,       1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1},
      '{i2cms_pkg::OP_STOP,       1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1},
      '{i2cms_pkg::OP_STOP,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      // address nack, then commands while aborted
      '{i2cms_pkg::OP_START_ADDR, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1},
      '{i2cms_pkg::OP_WRITE,      1'b0, 8'h5A, 1'b0, 8'h00, 1'b0},
      '{i2cms_pkg::OP_READ,       1'b0, 8'h00, 1'b0, 8'hA5, 1'b0},
      '{i2cms_pkg::OP_STOP,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      // data nack inside a read-direction transfer
      '{i2cms_pkg::OP_START_ADDR, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
      '{i2cms_pkg::OP_WRITE,      1'b0, 8'hA5, 1'b0, 8'h00, 1'b1},
      '{i2cms_pkg::OP_STOP,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      // read inside a write-direction transfer
      '{i2cms_pkg::OP_START_ADDR, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{i2cms_pkg::OP_READ,       1'b0, 8'h00, 1'b0, 8'h5A, 1'b0},
      '{i2cms_pkg::OP_WRITE,      1'b0, 8'h3C, 1'b0, 8'hFF, 1'b0},
      '{i2cms_pkg::OP_READ,       1'b1, 8'h00, 1'b1, 8'hFF, 1'b0},
      '{i2cms_pkg::OP_START_ADDR, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0}
    };
    rst                    = 1'b1;
    wr_en                  = 1'b0;
    wr_index               = i2cms_pkg::REG_SLAVE_ADDRESS;
    wr_data                = '0;
    cmd_if.valid           = 1'b0;
    cmd_if.operation       = i2cms_pkg::OP_START_ADDR;
    cmd_if.read_not_write  = 1'b0;
    cmd_if.data_byte       = 8'h00;
    cmd_if.final_read      = 1'b0;
    cmd_if.slave_bits      = 8'h00;
    cmd_if.slave_ack_level = 1'b0;
    evt_if.ready           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset settings
    foreach (opening[i]) add_cmd(opening[i]);
    wait_quiet();

    // random traffic across a range of settings
    program_bus(7'h7F, 10'd0);
    queue_traffic(44);
    wait_quiet();
    program_bus(7'h00, 10'd1023);
    queue_traffic(44);
    wait_quiet();
    full_rate = 1'b1;
    program_bus(7'($urandom_range(127)), 10'd1);
    queue_traffic(44);
    wait_quiet();
    full_rate = 1'b0;
    program_bus(7'($urandom_range(127)), 10'd1000);
    queue_traffic(44);
    wait_quiet();
    program_bus(7'($urandom_range(127)), 10'($urandom_range(1, 1000)));
    queue_traffic(44);
    wait_quiet();
    program_bus(7'h55, 10'($urandom_range(1023)));
    queue_traffic(44);
    wait_quiet();

    repeat (40) @(negedge clk);
    if (mismatches == 0 && due_events.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/i2cms_pkg.sv
rtl/i2cms_in_if.sv
rtl/i2cms_out_if.sv
rtl/i2cms_front.sv
rtl/i2cms_queue.sv
rtl/i2cms_back.sv
rtl/i2c_master_byte_sequencer_unit.sv
test/tb.sv
